// ===== hw/rtl/lru_key_value_cache_defines.svh =====
// Assertion shorthands used by the checker file.
// The enclosing module must provide clk and arst_n.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication.
`define LKVC_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication.
`define LKVC_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
package lkvc_pkg;

	// Default number of entries in the store.
	localparam int LKVC_MAX_ENTRIES = 16;

	// Field widths.
	localparam int CAP_W = 5;
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int RES_W = 32;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Result of a get that misses.
	localparam logic [RES_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Command codes.
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_PROMOTE,
		ST_PROMOTE_END,
		ST_RESPOND
	} lkvc_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;     // latch beat, clear scan results
		logic scan_rd;   // lookup sweep read
		logic decide;    // pick target entry; for a put, write value and new key
		logic upd_rd;    // recency update sweep read
		logic load_out;  // move result into output register
	} lkvc_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic idx_last;      // sweep index at last entry
		logic need_promote;  // item changes the recency order
		logic out_free;      // output register can take a result
	} lkvc_stat_t;

endpackage

// ===== hw/rtl/lkvc_ctrl.sv =====
module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  lkvc_stat_t stat,
	output lkvc_cmd_t  cmd
);

	lkvc_state_t state_q;
	lkvc_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_SCAN_END;
				end
			end
			// last lookup read is evaluated here
			ST_SCAN_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.need_promote ? ST_PROMOTE : ST_RESPOND;
			end
			ST_PROMOTE: begin
				cmd.upd_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_PROMOTE_END;
				end
			end
			// last rank write-back happens here
			ST_PROMOTE_END: begin
				state_d = ST_RESPOND;
			end
			ST_RESPOND: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/lkvc_dp.sv =====
module lkvc_dp
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    command,
	input  logic [KEY_W-1:0]        key,
	input  logic [VAL_W-1:0]        value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic signed [RES_W-1:0] read_value,
	input  lkvc_cmd_t               cmd,
	output lkvc_stat_t              stat
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

	// Entry storage
	logic [KEY_W-1:0] key_mem  [MAX_ENTRIES];
	logic [VAL_W-1:0] data_mem [MAX_ENTRIES];
	logic [IDX_W-1:0] rank_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0] occ_q;
	logic [CAP_W-1:0] cap_q;

	// Latched beat
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// Sweep index and read stage
	logic [IDX_W-1:0] idx_q;
	logic             scan_s1;
	logic             upd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [KEY_W-1:0] rd_key_s1;
	logic [VAL_W-1:0] rd_data_s1;
	logic [IDX_W-1:0] rd_rank_s1;

	// Lookup results
	logic             match_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [IDX_W-1:0] found_rank_q;
	logic [VAL_W-1:0] found_data_q;
	logic             free_any_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             vic_any_q;
	logic [IDX_W-1:0] vic_idx_q;
	logic [IDX_W-1:0] vic_rank_q;

	// Promotion target
	logic [IDX_W-1:0] tgt_idx_q;
	logic [IDX_W-1:0] limit_q;
	logic             limit_all_q;

	// Output register
	logic             out_valid_q;
	logic             res_hit_q;
	logic [RES_W-1:0] res_value_q;

	logic             rd_vld;
	logic             do_insert;
	logic [IDX_W-1:0] tgt_idx;
	logic             key_we;
	logic             data_we;
	logic             rank_we;
	logic [IDX_W-1:0] rank_wdata;

	assign rd_vld = valid_q[idx_s1];

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Beat latch
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q   <= command;
			key_q   <= key;
			value_q <= value;
		end
	end

	// Sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start || cmd.decide) begin
			idx_q <= '0;
		end else if (cmd.scan_rd || cmd.upd_rd) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign stat.idx_last     = (idx_q == IDX_LAST);
	assign stat.need_promote = match_q || (cmd_q == CMD_PUT);
	assign stat.out_free     = !out_valid_q || out_ready;

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			upd_s1  <= cmd.upd_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// Insert when a free entry exists and occupancy is below the capacity
	// (capacity zero counts as one)
	assign do_insert = (cmd_q == CMD_PUT) && !match_q && free_any_q &&
		((occ_q == '0) || (CMP_W'(occ_q) < CMP_W'(cap_q)));
	assign tgt_idx = match_q ? found_idx_q : (do_insert ? free_idx_q : vic_idx_q);

	assign key_we  = cmd.decide && (cmd_q == CMD_PUT) && !match_q;
	assign data_we = cmd.decide && (cmd_q == CMD_PUT);

	// Key and value memories
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[tgt_idx] <= key_q;
		end
		rd_key_s1 <= key_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[tgt_idx] <= value_q;
		end
		rd_data_s1 <= data_mem[idx_q];
	end

	// Rank write-back: target goes to zero, younger entries age by one
	always_comb begin
		rank_we    = 1'b0;
		rank_wdata = rd_rank_s1 + 1'b1;
		if (upd_s1) begin
			if (idx_s1 == tgt_idx_q) begin
				rank_we    = 1'b1;
				rank_wdata = '0;
			end else if (rd_vld && (limit_all_q || (rd_rank_s1 < limit_q))) begin
				rank_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[idx_s1] <= rank_wdata;
		end
		rd_rank_s1 <= rank_mem[idx_q];
	end

	// Valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.decide && do_insert) begin
			valid_q[tgt_idx] <= 1'b1;
			occ_q            <= occ_q + 1'b1;
		end
	end

	// Lookup evaluation: first match, lowest free, least recent valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (cmd.start) begin
			match_q    <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (scan_s1) begin
			if (rd_vld && (rd_key_s1 == key_q) && !match_q) begin
				match_q <= 1'b1;
			end
			if (!rd_vld && !free_any_q) begin
				free_any_q <= 1'b1;
			end
			if (rd_vld) begin
				vic_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			found_idx_q <= '0;
			free_idx_q  <= '0;
			vic_idx_q   <= '0;
			vic_rank_q  <= '0;
		end else if (scan_s1) begin
			if (rd_vld && (rd_key_s1 == key_q) && !match_q) begin
				found_idx_q  <= idx_s1;
				found_rank_q <= rd_rank_s1;
				found_data_q <= rd_data_s1;
			end
			if (!rd_vld && !free_any_q) begin
				free_idx_q <= idx_s1;
			end
			if (rd_vld && (!vic_any_q || (rd_rank_s1 >= vic_rank_q))) begin
				vic_idx_q  <= idx_s1;
				vic_rank_q <= rd_rank_s1;
			end
		end
	end

	// Promotion target and aging limit
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tgt_idx_q   <= tgt_idx;
			limit_q     <= match_q ? found_rank_q : vic_rank_q;
			limit_all_q <= do_insert;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_hit_q <= match_q;
			if (cmd_q == CMD_PUT) begin
				res_value_q <= '0;
			end else if (match_q) begin
				res_value_q <= {1'b0, found_data_q};
			end else begin
				res_value_q <= MISS_VALUE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = res_hit_q;
	assign read_value = res_value_q;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Channel   Handshake              Beat contents
// --------  ---------------------  -------------------------------------
// in        in_valid / in_ready    command, key, value
// out       out_valid / out_ready  hit, read_value
// cfg       cfg_we (no wait)       cfg_wdata -> capacity
//
// Each beat sweeps the entry memories once for lookup and, for a hit or a
// put, once more to update recency ranks, before the next beat is accepted;
// the sweeps run one after another because the key, value and rank memories
// each have a single read port. Reset clears valid bits, occupancy and
// control and sets capacity to 16; no clearing pass. A finished result waits
// in the output register while the next beat is taken; a stalled output
// holds only the response step.
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int MAX_ENTRIES = LKVC_MAX_ENTRIES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [KEY_W-1:0]        key,
	input  logic [VAL_W-1:0]        value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic signed [RES_W-1:0] read_value
);

	lkvc_cmd_t  cmd;
	lkvc_stat_t stat;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lkvc_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.command    (command),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

// ===== hw/rtl/lkvc_checker.sv =====
`include "lru_key_value_cache_defines.svh"

module lkvc_checker
	import lkvc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    hit,
	input logic signed [RES_W-1:0] read_value
);

	// stalled result beat holds
	`LKVC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(hit), "result changed while stalled")

	// one beat at a time: input closes after an accept
	`LKVC_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready, "input open right after accept")

	// a hit never reports the miss value
	`LKVC_ASSERT_IMP(a_hit_value, out_valid && hit, !read_value[RES_W-1], "negative value on hit")

	// a miss reports either zero (put) or the miss value (get)
	`LKVC_ASSERT_IMP(a_miss_value, out_valid && !hit, (read_value == '0) || (read_value == MISS_VALUE), "bad value on miss")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ===== verif/tb_lru_key_value_cache.sv =====
module tb_lru_key_value_cache;
	import lkvc_pkg::*;

	localparam int ENTRIES     = LKVC_MAX_ENTRIES;
	localparam int BUSY_CYCLES = 2 * ENTRIES + 5;   // accept-to-accept time of a hit or put, output not stalled
	localparam int STALL_LIMIT = 1000;              // cycles without any beat
	localparam int PHASE_ITEMS = 100;
	localparam int POOL_SIZE   = 24;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic             hit;
		logic [RES_W-1:0] read_value;
	} cache_reply_t;

	typedef enum logic {
		ROW_ACCESS,
		ROW_CAPACITY
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic             cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;     // capacity for ROW_CAPACITY rows
		logic             typed;   // reply below is fixed by hand
		cache_reply_t     reply;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CAP_W-1:0]        cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    command = CMD_GET;
	logic [KEY_W-1:0]        key = '0;
	logic [VAL_W-1:0]        value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    hit;
	logic signed [RES_W-1:0] read_value;

	// Shadow copy of the store
	logic [KEY_W-1:0] ent_key  [ENTRIES];
	logic [VAL_W-1:0] ent_data [ENTRIES];
	logic             ent_live [ENTRIES];
	int unsigned      ent_rank [ENTRIES];   // 0 = most recent
	int unsigned      live_count;
	logic [CAP_W-1:0] capacity_copy;

	cache_reply_t due_replies[$];
	stim_row_t    directed[$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	bit calm = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int n_results = 0;
	int n_gets = 0;
	int n_puts = 0;
	int n_hits = 0;
	int n_evictions = 0;
	int n_settings = 0;

	lru_key_value_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	// Entry e becomes most recent; live entries ranked ahead of limit age by one
	function automatic void make_recent(int e, int unsigned limit);
		for (int i = 0; i < ENTRIES; i++)
			if (i != e && ent_live[i] && ent_rank[i] < limit)
				ent_rank[i]++;
		ent_rank[e] = 0;
	endfunction

	// One get or put against the shadow store; returns the reply it causes
	function automatic cache_reply_t cache_access(logic cmd, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_reply_t r;
		int found;
		int slot;
		int unsigned limit;
		int unsigned worst;
		found = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && ent_live[i] && ent_key[i] == k)
				found = i;
		r.hit = (found >= 0);

		if (cmd == CMD_GET) begin
			if (found >= 0) begin
				r.read_value = {1'b0, ent_data[found]};
				make_recent(found, ent_rank[found]);
			end else begin
				r.read_value = MISS_VALUE;
			end
			return r;
		end

		r.read_value = '0;
		if (found >= 0) begin
			ent_data[found] = v;
			make_recent(found, ent_rank[found]);
			return r;
		end

		// zero counts as one, large values clip to the entry count
		limit = (capacity_copy == 0) ? 1 :
			((capacity_copy > ENTRIES) ? ENTRIES : capacity_copy);
		slot = -1;
		if (live_count < limit)
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !ent_live[i])
					slot = i;
		if (slot >= 0) begin
			ent_live[slot] = 1'b1;
			ent_key[slot]  = k;
			ent_data[slot] = v;
			make_recent(slot, ENTRIES);
			live_count++;
			return r;
		end

		// full: overwrite the least recent entry
		worst = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (ent_live[i] && (slot < 0 || ent_rank[i] >= worst)) begin
				slot  = i;
				worst = ent_rank[i];
			end
		if (slot >= 0) begin
			ent_key[slot]  = k;
			ent_data[slot] = v;
			make_recent(slot, worst);
			n_evictions++;
		end
		return r;
	endfunction

	function automatic void add_row(row_kind_t kind, logic cmd, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic typed, logic exp_hit, logic [RES_W-1:0] exp_value);
		stim_row_t row;
		row.kind             = kind;
		row.cmd              = cmd;
		row.key              = k;
		row.val              = v;
		row.typed            = typed;
		row.reply.hit        = exp_hit;
		row.reply.read_value = exp_value;
		directed.push_back(row);
	endfunction

	// Present one beat after a random gap; valid stays up on return
	task automatic send_item(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic typed, cache_reply_t typed_reply);
		int gap;
		cache_reply_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		predicted = cache_access(cmd, k, v);
		due_replies.push_back(typed ? typed_reply : predicted);
		if (cmd == CMD_GET) begin
			n_gets++;
			if (predicted.hit) n_hits++;
		end else begin
			n_puts++;
		end
	endtask

	// Stop sending and wait until every reply is back
	task automatic drain();
		in_valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] c);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_copy = c;
		n_settings++;
	endtask

	// Result side: random stalls on out_ready
	always @(posedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest pending reply
	always @(posedge clk) begin : reply_check
		cache_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_replies.size() == 0) begin
				if (mismatches < SHOW_LIMIT)
					$display("result %0d with nothing pending: hit=%0b read_value=%0d",
						n_results, hit, read_value);
				mismatches++;
			end else begin
				want = due_replies.pop_front();
				if (hit !== want.hit || read_value !== want.read_value) begin
					if (mismatches < SHOW_LIMIT)
						$display("result %0d: expected hit=%0b read_value=%0d, got hit=%0b read_value=%0d",
							n_results, want.hit, $signed(want.read_value), hit, read_value);
					mismatches++;
				end
			end
			n_results++;
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("timeout: %0d cycles without a beat, %0d replies pending",
				STALL_LIMIT, due_replies.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int cap_plan [9];
		int eff;
		int span;
		logic [KEY_W-1:0] k;
		logic cmd;

		foreach (ent_live[i]) begin
			ent_key[i]  = '0;
			ent_data[i] = '0;
			ent_live[i] = 1'b0;
			ent_rank[i] = 0;
		end
		live_count    = 0;
		capacity_copy = CAP_RESET;

		// Directed: field extremes, update in place, capacity zero, capacity
		// above the entry count, capacity dropped below occupancy
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0000, 31'h0, 1'b1, 1'b0, MISS_VALUE);
		add_row(ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, 1'b0, MISS_VALUE);
		add_row(ROW_ACCESS, CMD_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, 1'b1, 32'h7FFF_FFFF);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0000, 31'h0, 1'b1, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 1'b1, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b1, 1'b1, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, 1'b1, 32'h2AAA_AAAA);
		add_row(ROW_CAPACITY, CMD_GET, '0, 31'd0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0001, 31'h1555_5555, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0000, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0001, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_CAPACITY, CMD_GET, '0, 31'd31, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0002, 31'h1234_5678, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0003, 31'h0765_4321, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'hA5A5_A5A5, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_CAPACITY, CMD_GET, '0, 31'd2, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0004, 31'h0000_0044, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0001, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0005, 31'h0000_0055, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'hFFFF_FFFF, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0004, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_CAPACITY, CMD_GET, '0, 31'd16, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_PUT, 32'h0000_0006, 31'h7000_0001, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h0000_0006, 31'h0, 1'b0, 1'b0, '0);
		add_row(ROW_ACCESS, CMD_GET, 32'h5A5A_5A5A, 31'h3C3C_3C3C, 1'b0, 1'b0, '0);

		cap_plan = '{16, 0, 5, 31, 1, 17, 3, 12, 2};
		cap_plan[8] = $urandom_range(0, 31);
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CAPACITY)
				set_capacity(directed[i].val[CAP_W-1:0]);
			else
				send_item(directed[i].cmd, directed[i].key, directed[i].val,
					directed[i].typed, directed[i].reply);
		end

		// Random phases, one capacity each; keys mostly from a small pool
		// sized to the capacity so hits, updates and evictions all occur
		foreach (cap_plan[p]) begin
			set_capacity(CAP_W'(cap_plan[p]));
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 4; i++)
				key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
			eff  = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p]);
			span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, span - 1)]
					: $urandom();
				cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
				send_item(cmd, k, VAL_W'($urandom()), 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (BUSY_CYCLES) @(posedge clk);
		if (due_replies.size() != 0) begin
			$display("%0d expected results never arrived", due_replies.size());
			mismatches += due_replies.size();
		end

		$display("Covered %0d accesses (%0d gets, %0d puts) over %0d capacity settings;",
			n_gets + n_puts, n_gets, n_puts, n_settings);
		$display("%0d gets hit, %0d entries evicted, %0d results checked.",
			n_hits, n_evictions, n_results);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_dp.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkvc_checker.sv
verif/tb_lru_key_value_cache.sv
